// File: hw/rtl/wdlm_pkg.sv
// Shared types, codes and lock-word helpers for the wait-die lock manager.
package wdlm_pkg;

	localparam int ELEMENTS    = 256;
	localparam int MAX_OWNERS  = 8;
	localparam int MAX_WAITERS = 8;
	localparam int EL_W        = $clog2(ELEMENTS);
	localparam int IDX_W       = $clog2(MAX_OWNERS);
	localparam int CNT_W       = $clog2(MAX_OWNERS + 1);
	localparam int SLOTS       = ELEMENTS * MAX_OWNERS;
	localparam int SA_W        = $clog2(SLOTS);
	localparam int IN_W        = 104;
	localparam int OUT_W       = 32;

	localparam logic [1:0] MODE_ACQ  = 2'd0;
	localparam logic [1:0] MODE_CHK  = 2'd1;
	localparam logic [1:0] MODE_REL  = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	typedef enum logic [2:0] {
		RS_GRANTED  = 3'd0,
		RS_WAIT     = 3'd1,
		RS_ABORT    = 3'd2,
		RS_RELEASED = 3'd3,
		RS_WGRANTED = 3'd4,
		RS_FULL     = 3'd5,
		RS_NOTFOUND = 3'd6
	} rstat_t;

	typedef struct packed {
		logic       excl;
		logic [5:0] cnt;
	} lw_t;

	typedef struct packed {
		logic [5:0] srv;
		logic [7:0] tsk;
		logic [7:0] op;
		logic       excl;
	} tag_t;

	typedef struct packed {
		logic [63:0] stamp;
		tag_t        tag;
	} slot_t;

	typedef struct packed {
		lw_t              lw;
		logic [CNT_W-1:0] ocnt;
		logic [CNT_W-1:0] wcnt;
	} elem_t;

	localparam lw_t LW_FREE = '{excl: 1'b0, cnt: 6'd1};

	typedef enum logic [4:0] {
		S_IDLE, S_ELEM, S_HEAD, S_DEC,
		S_MW, S_MWC, S_MWDONE,
		S_WP, S_WPC, S_WS, S_WSW,
		S_RO, S_ROC, S_ROS, S_ROSW,
		S_RW, S_RWC, S_WD, S_WDW,
		S_GH, S_GC, S_GS, S_GSW
	} state_t;

	function automatic logic lk_conflict(lw_t w, logic x);
		lk_conflict = x ? (w.excl || (w.cnt > 6'd1)) : w.excl;
	endfunction

	function automatic lw_t lk_take(lw_t w, logic x);
		lw_t r;
		r = x ? lw_t'{excl: 1'b1, cnt: 6'd2} : lw_t'{excl: w.excl, cnt: w.cnt + 6'd1};
		lk_take = r;
	endfunction

	function automatic lw_t lk_release(lw_t w);
		lw_t r;
		r = w;
		if (w.excl) begin
			r = LW_FREE;
		end else if (w.cnt > 6'd1) begin
			r.cnt = w.cnt - 6'd1;
		end
		lk_release = r;
	endfunction

	// (as, asrv, at) strictly older than (bs, bsrv, bt)
	function automatic logic older(logic [63:0] as, logic [5:0] asrv, logic [7:0] at,
			logic [63:0] bs, logic [5:0] bsrv, logic [7:0] bt, logic use_task);
		if (as != bs) begin
			older = as < bs;
		end else if (asrv != bsrv) begin
			older = asrv < bsrv;
		end else begin
			older = use_task && (at < bt);
		end
	endfunction

endpackage

// File: hw/rtl/wdlm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wdlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hw/rtl/wait_die_lock_manager_core.sv
// Wait-die lock table over 256 elements. One request is taken at a time
// (s_tready high only when idle) and each one, MODE_NONE apart, produces one
// or more results on the master side, the final one flagged by tlast.
// Owner and waiter slots are scanned or shifted one at a time, and a release
// adds a head check and a list shift per granted waiter. The pace is set by
// the owner and waiter slot memories, which give one read and one write per
// cycle, and by the single shared age comparator. Per-element state has a
// valid bit per element, so no clearing pass runs after reset.
module wait_die_lock_manager_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// mode, element, access_kind, stamp, requester, task_req, operation
	input  logic [wdlm_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status, to_server, to_task, to_operation
	output logic [wdlm_pkg::OUT_W-1:0] m_tdata,
	output logic                       m_tlast
);
	import wdlm_pkg::*;

	state_t state_q, state_d;

	logic [1:0]       mode_q;
	logic [EL_W-1:0]  el_q;
	logic             excl_q;
	logic [63:0]      ts_q;
	logic [5:0]       srv_q;
	logic [7:0]       task_q;
	logic [7:0]       op_q;

	logic [CNT_W-1:0] cnt_q, cnt_d, pos_q, pos_d, ocnt_q, ocnt_d, wcnt_q, wcnt_d;
	lw_t              lw_q, lw_d;
	logic             conf_q, conf_d, mwok_q, mwok_d;
	tag_t             pend_q, pend_d;
	logic [2:0]       pst_q, pst_d;

	logic             m_tvalid_q, m_tlast_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic             emit, em_last;
	logic [2:0]       em_st;
	tag_t             em_tag;
	logic             out_free, s_fire;

	logic             o_re, o_we, w_re, w_we;
	logic [IDX_W-1:0] o_ridx, o_widx, w_ridx, w_widx;
	slot_t            o_wdata, w_wdata, o_rd, w_rd;

	elem_t            elem_rd, elem_ev, elem_wdata;
	logic             elem_we;
	logic [ELEMENTS-1:0] elem_vld_q;
	logic             elem_vld_rd_q;

	logic [63:0]      ca_stamp;
	logic [5:0]       ca_srv, cb_srv;
	logic [7:0]       ca_task, cb_task;
	logic             c_use_task, c_older;

	tag_t             req_tag;
	logic             o_match, w_match, grant;
	logic [CNT_W-1:0] cnt_inc, cnt_dec;

	assign s_fire   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign req_tag  = '{srv: srv_q, tsk: task_q, op: op_q, excl: excl_q};
	assign o_match  = (o_rd.tag[22:1] == req_tag[22:1]);
	assign w_match  = (w_rd.tag[22:1] == req_tag[22:1]);
	assign grant    = !lk_conflict(lw_q, w_rd.tag.excl);
	assign cnt_inc  = cnt_q + 1'b1;
	assign cnt_dec  = cnt_q - 1'b1;
	assign elem_ev  = elem_vld_rd_q ? elem_rd
			: elem_t'{lw: LW_FREE, ocnt: '0, wcnt: '0};
	assign elem_wdata = '{lw: lw_d, ocnt: ocnt_d, wcnt: wcnt_d};
	assign elem_we  = emit && em_last;

	wdlm_ram #(.WIDTH($bits(elem_t)), .DEPTH(ELEMENTS)) u_elem (
		.clk(clk), .we(elem_we), .waddr(el_q), .wdata(elem_wdata),
		.re(s_fire), .raddr(s_tdata[9:2]), .rdata(elem_rd)
	);
	wdlm_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_owner (
		.clk(clk), .we(o_we), .waddr(SA_W'({el_q, o_widx})), .wdata(o_wdata),
		.re(o_re), .raddr(SA_W'({el_q, o_ridx})), .rdata(o_rd)
	);
	wdlm_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_waiter (
		.clk(clk), .we(w_we), .waddr(SA_W'({el_q, w_widx})), .wdata(w_wdata),
		.re(w_re), .raddr(SA_W'({el_q, w_ridx})), .rdata(w_rd)
	);

	// shared age comparator; head check compares stamps only
	always_comb begin
		ca_stamp   = (state_q == S_MWC) ? o_rd.stamp : w_rd.stamp;
		ca_srv     = (state_q == S_MWC) ? o_rd.tag.srv : w_rd.tag.srv;
		ca_task    = (state_q == S_MWC) ? o_rd.tag.tsk : w_rd.tag.tsk;
		cb_srv     = srv_q;
		cb_task    = task_q;
		c_use_task = (state_q == S_WPC) || ((state_q == S_MWC) && (mode_q == MODE_ACQ));
		if (state_q == S_HEAD) begin
			ca_srv  = '0;
			ca_task = '0;
			cb_srv  = '0;
			cb_task = '0;
		end
	end
	assign c_older = older(ca_stamp, ca_srv, ca_task, ts_q, cb_srv, cb_task, c_use_task);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_fire && (s_tdata[1:0] != MODE_NONE)) state_d = S_ELEM;
			S_ELEM: begin
				if (mode_q == MODE_REL) begin
					state_d = (elem_ev.ocnt != '0) ? S_RO : S_RW;
				end else if (!lk_conflict(elem_ev.lw, excl_q) && (elem_ev.wcnt != '0)) begin
					state_d = S_HEAD;
				end else begin
					state_d = S_DEC;
				end
			end
			S_HEAD: state_d = S_DEC;
			S_DEC: begin
				if (conf_q) begin
					state_d = S_MW;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_MW:  state_d = (cnt_q == ocnt_q) ? S_MWDONE : S_MWC;
			S_MWC: state_d = c_older ? S_MWDONE : S_MW;
			S_MWDONE: begin
				if (mode_q == MODE_ACQ && mwok_q && wcnt_q < CNT_W'(MAX_WAITERS)) begin
					state_d = S_WP;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_WP:  state_d = (cnt_q == wcnt_q) ? S_WS : S_WPC;
			S_WPC: state_d = c_older ? S_WS : S_WP;
			S_WS: begin
				if (cnt_q != pos_q) begin
					state_d = S_WSW;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_WSW: state_d = S_WS;
			S_RO:  state_d = (cnt_q == '0) ? S_RW : S_ROC;
			S_ROC: state_d = o_match ? S_ROS : S_RO;
			S_ROS: state_d = (cnt_inc == ocnt_q) ? S_GH : S_ROSW;
			S_ROSW: state_d = S_ROS;
			S_RW: begin
				if (cnt_q != wcnt_q) begin
					state_d = S_RWC;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_RWC: state_d = w_match ? S_WD : S_RW;
			S_WD:  state_d = (cnt_inc == wcnt_q) ? S_GH : S_WDW;
			S_WDW: state_d = S_WD;
			S_GH: begin
				if (wcnt_q != '0 && ocnt_q < CNT_W'(MAX_OWNERS)) begin
					state_d = S_GC;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_GC:  if (out_free) state_d = grant ? S_GS : S_IDLE;
			S_GS:  state_d = (cnt_inc == wcnt_q) ? S_GH : S_GSW;
			S_GSW: state_d = S_GS;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		cnt_d = cnt_q; pos_d = pos_q; conf_d = conf_q; mwok_d = mwok_q;
		lw_d = lw_q; ocnt_d = ocnt_q; wcnt_d = wcnt_q;
		pend_d = pend_q; pst_d = pst_q;
		o_re = 1'b0; o_we = 1'b0; w_re = 1'b0; w_we = 1'b0;
		o_ridx = cnt_q[IDX_W-1:0]; o_widx = cnt_q[IDX_W-1:0];
		w_ridx = cnt_q[IDX_W-1:0]; w_widx = cnt_q[IDX_W-1:0];
		o_wdata = o_rd; w_wdata = w_rd;
		emit = 1'b0; em_last = 1'b1; em_st = RS_GRANTED; em_tag = req_tag;
		case (state_q)
			S_ELEM: begin
				lw_d = elem_ev.lw; ocnt_d = elem_ev.ocnt; wcnt_d = elem_ev.wcnt;
				conf_d = lk_conflict(elem_ev.lw, excl_q);
				cnt_d = (mode_q == MODE_REL) ? elem_ev.ocnt : '0;
				if (mode_q != MODE_REL && !conf_d && elem_ev.wcnt != '0) begin
					w_re = 1'b1; w_ridx = '0;
				end
			end
			S_HEAD: conf_d = !c_older;
			S_DEC: begin
				mwok_d = 1'b1;
				if (!conf_q && out_free) begin
					emit = 1'b1;
					if (mode_q == MODE_CHK) begin
						em_st = RS_GRANTED;
					end else if (ocnt_q >= CNT_W'(MAX_OWNERS)) begin
						em_st = RS_FULL;
					end else begin
						em_st = RS_GRANTED;
						o_we = 1'b1; o_widx = ocnt_q[IDX_W-1:0];
						o_wdata = '{stamp: ts_q, tag: req_tag};
						lw_d = lk_take(lw_q, excl_q);
						ocnt_d = ocnt_q + 1'b1;
					end
				end
			end
			S_MW: begin
				if (cnt_q != ocnt_q) o_re = 1'b1;
			end
			S_MWC: begin
				if (c_older) mwok_d = 1'b0;
				else cnt_d = cnt_inc;
			end
			S_MWDONE: begin
				cnt_d = '0;
				if (mode_q == MODE_CHK) begin
					emit = out_free; em_st = mwok_q ? RS_WAIT : RS_ABORT;
				end else if (!mwok_q) begin
					emit = out_free; em_st = RS_ABORT;
				end else if (wcnt_q >= CNT_W'(MAX_WAITERS)) begin
					emit = out_free; em_st = RS_FULL;
				end
			end
			S_WP: begin
				if (cnt_q == wcnt_q) begin
					pos_d = wcnt_q;
				end else begin
					w_re = 1'b1;
				end
			end
			S_WPC: begin
				if (c_older) begin
					pos_d = cnt_q; cnt_d = wcnt_q;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			S_WS: begin
				if (cnt_q != pos_q) begin
					w_re = 1'b1; w_ridx = cnt_dec[IDX_W-1:0];
				end else if (out_free) begin
					w_we = 1'b1; w_widx = pos_q[IDX_W-1:0];
					w_wdata = '{stamp: ts_q, tag: req_tag};
					wcnt_d = wcnt_q + 1'b1;
					emit = 1'b1; em_st = RS_WAIT;
				end
			end
			S_WSW: begin
				w_we = 1'b1; cnt_d = cnt_dec;
			end
			S_RO: begin
				if (cnt_q != '0) begin
					o_re = 1'b1; o_ridx = cnt_dec[IDX_W-1:0];
				end
			end
			S_ROC: cnt_d = cnt_dec;
			S_ROS: begin
				if (cnt_inc == ocnt_q) begin
					ocnt_d = ocnt_q - 1'b1;
					lw_d = lk_release(lw_q);
					pend_d = req_tag; pst_d = RS_RELEASED;
				end else begin
					o_re = 1'b1; o_ridx = cnt_inc[IDX_W-1:0];
				end
			end
			S_ROSW: begin
				o_we = 1'b1; cnt_d = cnt_inc;
			end
			S_RW: begin
				if (cnt_q != wcnt_q) begin
					w_re = 1'b1;
				end else begin
					emit = out_free; em_st = RS_NOTFOUND;
				end
			end
			S_RWC: if (!w_match) cnt_d = cnt_inc;
			S_WD, S_GS: begin
				if (cnt_inc == wcnt_q) begin
					wcnt_d = wcnt_q - 1'b1;
					if (state_q == S_WD) begin
						pend_d = req_tag; pst_d = RS_RELEASED;
					end else begin
						ocnt_d = ocnt_q + 1'b1;
					end
				end else begin
					w_re = 1'b1; w_ridx = cnt_inc[IDX_W-1:0];
				end
			end
			S_WDW, S_GSW: begin
				w_we = 1'b1; cnt_d = cnt_inc;
			end
			S_GH: begin
				cnt_d = '0;
				if (wcnt_q != '0 && ocnt_q < CNT_W'(MAX_OWNERS)) begin
					w_re = 1'b1; w_ridx = '0;
				end else begin
					emit = out_free; em_st = pst_q; em_tag = pend_q;
				end
			end
			S_GC: begin
				if (out_free) begin
					emit = 1'b1; em_st = pst_q; em_tag = pend_q; em_last = !grant;
					if (grant) begin
						o_we = 1'b1; o_widx = ocnt_q[IDX_W-1:0]; o_wdata = w_rd;
						lw_d = lk_take(lw_q, w_rd.tag.excl);
						pend_d = w_rd.tag; pst_d = RS_WGRANTED;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			elem_vld_q <= '0;
			cnt_q      <= '0;
			ocnt_q     <= '0;
			wcnt_q     <= '0;
			lw_q       <= LW_FREE;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ocnt_q  <= ocnt_d;
			wcnt_q  <= wcnt_d;
			lw_q    <= lw_d;
			if (elem_we) elem_vld_q[el_q] <= 1'b1;
			if (emit) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		conf_q <= conf_d;
		mwok_q <= mwok_d;
		pend_q <= pend_d;
		pst_q  <= pst_d;
		if (s_fire) begin
			mode_q        <= s_tdata[1:0];
			el_q          <= s_tdata[9:2];
			excl_q        <= (s_tdata[11:10] != 2'd0);
			ts_q          <= s_tdata[75:12];
			srv_q         <= s_tdata[81:76];
			task_q        <= s_tdata[89:82];
			op_q          <= s_tdata[97:90];
			elem_vld_rd_q <= elem_vld_q[s_tdata[9:2]];
		end
		if (emit) begin
			m_tdata_q <= {7'd0, em_tag.op, em_tag.tsk, em_tag.srv, em_st};
			m_tlast_q <= em_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= CNT_W'(MAX_OWNERS)) else $error("owner count overflow");
	a_wcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= CNT_W'(MAX_WAITERS)) else $error("waiter count overflow");
	a_excl_word: assert property (@(posedge clk) disable iff (!arst_n)
		lw_q.excl |-> (lw_q.cnt == 6'd2)) else $error("bad exclusive lock word");
	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !emit) else $error("result overwritten");
endmodule
